[design/rlbc_pkg.sv]
// Shared types, constants and codes for the reference-counted LRU cache.
`default_nettype none
package rlbc_pkg;

  // Geometry of the table.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  // Stored key width; keys are taken from the low bits of the 32-bit key word (at most 32).
  localparam int KEY_BITS = 32;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 4;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int USE_W    = 16;
  localparam int STAMP_W  = 32;
  localparam int CAP_W    = 5;
  localparam int PADDR_W  = 3;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSTALLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]   CAP_RESET     = 5'd16;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [USE_W-1:0]    use_cnt;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } cmd_t;

endpackage
`default_nettype wire

[design/rlbc_regs.sv]
// Configuration register file: the capacity register behind the APB port.
`default_nettype none
module rlbc_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rlbc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output logic      [rlbc_pkg::CAP_W-1:0]   cap
);
  import rlbc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             sel_cap;

  // Word decode ignores the byte offset within the word.
  assign sel_cap = (paddr[PADDR_W-1:2] == ADDR_CAPACITY[PADDR_W-1:2]);
  assign pready  = 1'b1;

  // Capacity register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = 32'(cap_r);
    end
  end

  assign cap = cap_r;

endmodule
`default_nettype wire

[design/rlbc_ctrl.sv]
// Controller state machine: sequences the table scan, release read and commit.
`default_nettype none
module rlbc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       in_req_type,
  input  wire logic [rlbc_pkg::HANDLE_W-1:0] in_handle,
  output logic                  busy,
  output rlbc_pkg::cmd_t        cmd
);
  import rlbc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_RADDR  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [HANDLE_W-1:0] handle_r;
  logic              accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          unique case (req_t'(in_req_type))
            REQ_GET:     state_nxt = S_SCAN;
            REQ_RELEASE: state_nxt = S_RADDR;
            default:     state_nxt = S_COMMIT;
          endcase
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_COMMIT;
      S_RADDR:  state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The release handle is held for the memory read.
  always_ff @(posedge clk) begin
    if (accept) begin
      handle_r <= in_handle;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load    = accept;
    cmd.scan    = (state_r == S_SCAN);
    cmd.commit  = (state_r == S_COMMIT);
    cmd.rd_addr = (state_r == S_RADDR) ? IDX_W'(handle_r) : cnt_r;
  end

endmodule
`default_nettype wire

[design/rlbc_dp.sv]
// Datapath: entry memory, valid bits, scan trackers, commit logic and result word.
`default_nettype none
module rlbc_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rlbc_pkg::cmd_t                cmd,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [rlbc_pkg::KEY_W-1:0]    in_key,
  input  wire logic [rlbc_pkg::HANDLE_W-1:0] in_handle,
  input  wire logic [rlbc_pkg::CAP_W-1:0]    cap,
  output logic                               out_valid,
  output logic [rlbc_pkg::STATUS_W-1:0]      out_status,
  output logic [rlbc_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_evicted_valid,
  output logic [rlbc_pkg::KEY_W-1:0]         out_evicted_key
);
  import rlbc_pkg::*;

  // Entry memory and its registered read port.
  entry_t              mem [DEPTH];
  entry_t              rd_data_r;
  logic                we;
  logic [IDX_W-1:0]    wa;
  entry_t              wd;

  // Table state.
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [STAMP_W-1:0]  acc_r, acc_nxt;

  // Latched request.
  req_t                req_r;
  logic [KEY_BITS-1:0] key_r;
  logic [HANDLE_W-1:0] handle_r;

  // Scan pipeline and trackers.
  logic                scan_vld_r;
  logic [IDX_W-1:0]    idx_d_r;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    found_slot_r, found_slot_nxt;
  logic [USE_W-1:0]    found_use_r, found_use_nxt;
  logic                vic_have_r, vic_have_nxt;
  logic [IDX_W-1:0]    vic_slot_r, vic_slot_nxt;
  logic [STAMP_W-1:0]  vic_stamp_r, vic_stamp_nxt;
  logic [KEY_BITS-1:0] vic_key_r, vic_key_nxt;
  logic                free_have_r, free_have_nxt;
  logic [IDX_W-1:0]    free_slot_r, free_slot_nxt;
  logic                cur_vld;

  // Commit results.
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                ev_valid_r, ev_valid_nxt;
  logic [KEY_W-1:0]    ev_key_r, ev_key_nxt;
  logic [CNT_W-1:0]    eff_cap;
  logic [IDX_W-1:0]    h_idx;
  logic                h_ok;

  // Memory write and read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[cmd.rd_addr];
  end

  // Request latch and scan index pipeline.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_t'(in_req_type);
      key_r    <= in_key[KEY_BITS-1:0];
      handle_r <= in_handle;
    end
    idx_d_r <= cmd.rd_addr;
  end

  // Tracker update over the entries read back during the scan.
  assign cur_vld = valid_r[idx_d_r];

  always_comb begin
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    found_use_nxt  = found_use_r;
    vic_have_nxt   = vic_have_r;
    vic_slot_nxt   = vic_slot_r;
    vic_stamp_nxt  = vic_stamp_r;
    vic_key_nxt    = vic_key_r;
    free_have_nxt  = free_have_r;
    free_slot_nxt  = free_slot_r;
    if (cmd.load) begin
      found_nxt     = 1'b0;
      vic_have_nxt  = 1'b0;
      free_have_nxt = 1'b0;
    end else if (scan_vld_r) begin
      // First valid entry with a matching key.
      if (cur_vld && !found_r && (rd_data_r.key == key_r)) begin
        found_nxt      = 1'b1;
        found_slot_nxt = idx_d_r;
        found_use_nxt  = rd_data_r.use_cnt;
      end
      // Oldest idle entry; a strict compare keeps the lowest index on a tie.
      if (cur_vld && (rd_data_r.use_cnt == '0) &&
          (!vic_have_r || (rd_data_r.stamp < vic_stamp_r))) begin
        vic_have_nxt  = 1'b1;
        vic_slot_nxt  = idx_d_r;
        vic_stamp_nxt = rd_data_r.stamp;
        vic_key_nxt   = rd_data_r.key;
      end
      // Lowest free slot.
      if (!cur_vld && !free_have_r) begin
        free_have_nxt = 1'b1;
        free_slot_nxt = idx_d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_vld_r <= 1'b0;
    end else begin
      scan_vld_r <= cmd.scan;
    end
    found_r      <= found_nxt;
    found_slot_r <= found_slot_nxt;
    found_use_r  <= found_use_nxt;
    vic_have_r   <= vic_have_nxt;
    vic_slot_r   <= vic_slot_nxt;
    vic_stamp_r  <= vic_stamp_nxt;
    vic_key_r    <= vic_key_nxt;
    free_have_r  <= free_have_nxt;
    free_slot_r  <= free_slot_nxt;
  end

  // Effective capacity: zero acts as one, anything above the depth as the depth.
  always_comb begin
    eff_cap = CNT_W'(cap);
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end
  end

  assign h_idx = IDX_W'(handle_r);
  assign h_ok  = (32'(handle_r) < DEPTH) && valid_r[h_idx];

  // Commit: table update and result word.
  always_comb begin
    we           = 1'b0;
    wa           = '0;
    wd           = rd_data_r;
    valid_nxt    = valid_r;
    held_nxt     = held_r;
    acc_nxt      = acc_r;
    status_nxt   = ST_NOT_FOUND;
    slot_nxt     = '0;
    ev_valid_nxt = 1'b0;
    ev_key_nxt   = '0;
    if (cmd.commit) begin
      case (req_r)
        REQ_GET: begin
          if (found_r) begin
            we         = 1'b1;
            wa         = found_slot_r;
            wd.key     = key_r;
            wd.use_cnt = (found_use_r == '1) ? found_use_r : found_use_r + 1'b1;
            wd.stamp   = acc_r;
            acc_nxt    = acc_r + 1'b1;
            status_nxt = ST_HIT;
            slot_nxt   = SLOT_W'(found_slot_r);
          end else if (held_r >= eff_cap) begin
            if (vic_have_r) begin
              we           = 1'b1;
              wa           = vic_slot_r;
              wd.key       = key_r;
              wd.use_cnt   = USE_W'(1);
              wd.stamp     = acc_r;
              acc_nxt      = acc_r + 1'b1;
              status_nxt   = ST_INSTALLED;
              slot_nxt     = SLOT_W'(vic_slot_r);
              ev_valid_nxt = 1'b1;
              ev_key_nxt   = KEY_W'(vic_key_r);
            end else begin
              status_nxt = ST_NO_VICTIM;
            end
          end else if (free_have_r) begin
            we                     = 1'b1;
            wa                     = free_slot_r;
            wd.key                 = key_r;
            wd.use_cnt             = USE_W'(1);
            wd.stamp               = acc_r;
            valid_nxt[free_slot_r] = 1'b1;
            held_nxt               = held_r + 1'b1;
            acc_nxt                = acc_r + 1'b1;
            status_nxt             = ST_INSTALLED;
            slot_nxt               = SLOT_W'(free_slot_r);
          end else begin
            status_nxt = ST_NO_VICTIM;
          end
        end
        REQ_RELEASE: begin
          slot_nxt = SLOT_W'(handle_r);
          if (h_ok) begin
            we         = 1'b1;
            wa         = h_idx;
            wd.use_cnt = (rd_data_r.use_cnt == '0) ? rd_data_r.use_cnt
                                                   : rd_data_r.use_cnt - 1'b1;
            status_nxt = ST_RELEASED;
          end
        end
        REQ_CLEAR: begin
          valid_nxt  = '0;
          held_nxt   = '0;
          status_nxt = ST_CLEARED;
        end
        default: begin
          slot_nxt = SLOT_W'(handle_r);
        end
      endcase
    end
  end

  // Table state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      held_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      held_r      <= held_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= cmd.commit;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r   <= status_nxt;
      slot_r     <= slot_nxt;
      ev_valid_r <= ev_valid_nxt;
      ev_key_r   <= ev_key_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_key   = ev_key_r;

endmodule
`default_nettype wire

[design/refcounted_lru_buffer_cache_top.sv]
// Top level of the reference-counted LRU cache: register file, controller and datapath.
// A get runs from accept through the scan state, which reads the entry memory one entry per
// cycle, then the drain and commit states; a release runs through the handle read and commit,
// a clear through commit alone. One request at a time: busy falls as the result is driven.
// The result strobe out_valid cannot be stalled by the receiver.
// Reset (rst_n low, synchronous) empties the table, zeroes the access counter and sets
// capacity to 16; no clearing pass is needed.
`default_nettype none
module refcounted_lru_buffer_cache_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [rlbc_pkg::KEY_W-1:0]    in_key,
  input  wire logic [rlbc_pkg::HANDLE_W-1:0] in_handle,
  output logic                               out_valid,
  output logic [rlbc_pkg::STATUS_W-1:0]      out_status,
  output logic [rlbc_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_evicted_valid,
  output logic [rlbc_pkg::KEY_W-1:0]         out_evicted_key,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rlbc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import rlbc_pkg::*;

  cmd_t             cmd;
  logic [CAP_W-1:0] cap;

  rlbc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  rlbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .in_handle   (in_handle),
    .busy        (busy),
    .cmd         (cmd)
  );

  rlbc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .in_handle         (in_handle),
    .cap               (cap),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_key   (out_evicted_key)
  );

endmodule
`default_nettype wire

[design/rlbc_checker.sv]
// Port-level checker for the cache top level, with its bind statement.
`default_nettype none
module rlbc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [rlbc_pkg::STATUS_W-1:0] out_status,
  input wire logic                          out_evicted_valid
);
  import rlbc_pkg::*;

  // Every accepted request raises busy in the cycle after it is accepted.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result word appears only at the end of a request.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result word without a request in progress");

  // Finishing a request always delivers its result word.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result word");

  // An eviction is reported only with an install.
  a_evict_install: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> (out_status == ST_INSTALLED))
    else $error("eviction reported on a non-install result");

  // Only defined status codes are returned.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_HIT || out_status == ST_INSTALLED ||
                   out_status == ST_NO_VICTIM || out_status == ST_RELEASED ||
                   out_status == ST_NOT_FOUND || out_status == ST_CLEARED))
    else $error("undefined status code");

endmodule

bind refcounted_lru_buffer_cache_top rlbc_checker u_rlbc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_evicted_valid (out_evicted_valid)
);
`default_nettype wire
